[src/utdt_pkg.sv]
// ----------------------------------------------------------------------------
// utdt_pkg
// Shared constants and the month table for the timestamp to date converter.
// ----------------------------------------------------------------------------
package utdt_pkg;

  // Pipeline depth: stage A (offset add) through stage H (output register).
  localparam int STAGES     = 8;
  // Stages D..H run in the time-of-day and date parts.
  localparam int SUB_STAGES = 5;

  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;

  // (t >> 7) / 675 gives the day number: floor(2^35 / 675), one correction step.
  localparam logic [25:0] RECIP_675     = 26'd50903316;
  localparam logic [24:0] DIV_675       = 25'd675;
  // (sod >> 4) / 225 exact as (x * 4661) >> 20 over the range 0..5399.
  localparam logic [12:0] RECIP_225     = 13'd4661;
  // (ms >> 2) / 15 exact as (x * 1093) >> 14 over the range 0..899.
  localparam logic [10:0] RECIP_15      = 11'd1093;
  // day / 1461 exact as (x * 45934) >> 26 over the range 0..50442.
  localparam logic [15:0] RECIP_1461    = 16'd45934;
  localparam logic [15:0] DAYS_PER_QUAD = 16'd1461;

  // Count days from 1968-01-01, the leap year that opens a four-year cycle.
  localparam logic [15:0] EPOCH_SHIFT   = 16'd731;
  // Day number of 2100-03-01 from 1970-01-01; skip the missing 2100-02-29.
  localparam logic [15:0] MAR_2100      = 16'd47541;
  localparam logic [11:0] BASE_YEAR     = 12'd1968;

  // First day of the year (0-based) on which a month starts.
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && m > 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

[src/utdt_tod.sv]
// ----------------------------------------------------------------------------
// utdt_tod
// Time-of-day split: seconds of the day into hour, minute and second,
// pipeline stages D through H.
// ----------------------------------------------------------------------------
module utdt_tod (
  input  logic                                clk,
  input  logic [utdt_pkg::SUB_STAGES-1:0]     adv,
  input  logic [16:0]                         sod,
  output logic [5:0]                          second,
  output logic [5:0]                          minute,
  output logic [4:0]                          hour
);

  logic [16:0] sod_d;
  logic [4:0]  hour_d;
  logic [11:0] ms_e;
  logic [4:0]  hour_e;
  logic [11:0] ms_f;
  logic [5:0]  min_f;
  logic [4:0]  hour_f;
  logic [5:0]  sec_g;
  logic [5:0]  min_g;
  logic [4:0]  hour_g;

  logic [25:0] hour_prod;
  logic [16:0] hour_secs;
  logic [16:0] ms_full;
  logic [20:0] min_prod;
  logic [11:0] min_secs;
  logic [11:0] sec_full;

  assign hour_prod = 26'(sod[16:4]) * 26'(utdt_pkg::RECIP_225);
  assign hour_secs = 17'(hour_d) * utdt_pkg::SECS_PER_HOUR;
  assign ms_full   = sod_d - hour_secs;
  assign min_prod  = 21'(ms_e[11:2]) * 21'(utdt_pkg::RECIP_15);
  assign min_secs  = 12'(min_f) * utdt_pkg::SECS_PER_MIN;
  assign sec_full  = ms_f - min_secs;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sod_d  <= sod;
      hour_d <= hour_prod[24:20];
    end
    if (adv[1]) begin
      ms_e   <= ms_full[11:0];
      hour_e <= hour_d;
    end
    if (adv[2]) begin
      ms_f   <= ms_e;
      min_f  <= min_prod[19:14];
      hour_f <= hour_e;
    end
    if (adv[3]) begin
      sec_g  <= sec_full[5:0];
      min_g  <= min_f;
      hour_g <= hour_f;
    end
    if (adv[4]) begin
      second <= sec_g;
      minute <= min_g;
      hour   <= hour_g;
    end
  end

endmodule

[src/utdt_date.sv]
// ----------------------------------------------------------------------------
// utdt_date
// Calendar split: day count since the epoch into year, month and day,
// pipeline stages D through H.
// ----------------------------------------------------------------------------
module utdt_date (
  input  logic                                clk,
  input  logic [utdt_pkg::SUB_STAGES-1:0]     adv,
  input  logic [15:0]                         days,
  output logic [4:0]                          day,
  output logic [3:0]                          month,
  output logic [11:0]                         year
);

  logic [15:0] dp_d;
  logic [15:0] dp_e;
  logic [5:0]  cyc_e;
  logic [10:0] dc_f;
  logic [5:0]  cyc_f;
  logic [8:0]  doy_g;
  logic        leap_g;
  logic [11:0] year_g;

  logic [15:0] dp_next;
  logic [31:0] cyc_prod;
  logic [15:0] quad_days;
  logic [15:0] dc_full;
  logic [1:0]  yoff;
  logic [10:0] yoff_base;
  logic [10:0] doy_full;
  logic [3:0]  mon_sel;
  logic [8:0]  mon_base;
  logic [8:0]  dom;

  // Pretend 2100 is a leap year once past its February: the extra day is never hit.
  assign dp_next   = days + utdt_pkg::EPOCH_SHIFT
                   + ((days >= utdt_pkg::MAR_2100) ? 16'd1 : 16'd0);
  assign cyc_prod  = 32'(dp_d) * 32'(utdt_pkg::RECIP_1461);
  assign quad_days = 16'(cyc_e) * utdt_pkg::DAYS_PER_QUAD;
  assign dc_full   = dp_e - quad_days;

  always_comb begin
    if (dc_f < 11'd366) begin
      yoff      = 2'd0;
      yoff_base = 11'd0;
    end else if (dc_f < 11'd731) begin
      yoff      = 2'd1;
      yoff_base = 11'd366;
    end else if (dc_f < 11'd1096) begin
      yoff      = 2'd2;
      yoff_base = 11'd731;
    end else begin
      yoff      = 2'd3;
      yoff_base = 11'd1096;
    end
    doy_full = dc_f - yoff_base;
  end

  // Last month whose first day is not past the day of the year.
  always_comb begin
    mon_sel  = 4'd1;
    mon_base = 9'd0;
    for (int m = 2; m <= 12; m++) begin
      if (doy_g >= utdt_pkg::month_start(4'(m), leap_g)) begin
        mon_sel  = 4'(m);
        mon_base = utdt_pkg::month_start(4'(m), leap_g);
      end
    end
    dom = doy_g - mon_base + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dp_d <= dp_next;
    end
    if (adv[1]) begin
      dp_e  <= dp_d;
      cyc_e <= cyc_prod[31:26];
    end
    if (adv[2]) begin
      dc_f  <= dc_full[10:0];
      cyc_f <= cyc_e;
    end
    if (adv[3]) begin
      doy_g  <= doy_full[8:0];
      leap_g <= (yoff == 2'd0);
      year_g <= utdt_pkg::BASE_YEAR + {4'd0, cyc_f, 2'b00} + 12'(yoff);
    end
    if (adv[4]) begin
      day   <= dom[4:0];
      month <= mon_sel;
      year  <= year_g;
    end
  end

endmodule

[src/unix_time_to_date_and_time_core.sv]
// ----------------------------------------------------------------------------
// unix_time_to_date_and_time_core
// Unix timestamp to Gregorian local date and time of day.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with timestamp (seconds since the epoch).
// Output channel: out_valid / out_stall with second, minute, hour, day, month
// and year of local time. A transfer happens on a rising edge with valid high
// and stall low. Every timestamp gives exactly one result, in order.
// tz_offset_hours (signed whole hours) is written while tz_offset_we is high;
// the local time is the timestamp plus the offset times 3600, modulo 2^32.
// Write it only while no transfer is in flight.
// Throughput is one timestamp per cycle while the receiver does not stall,
// through the 8-stage pipeline (offset add, two steps for the divide by
// 86400, then five stages of time-of-day and calendar split).
// When the receiver stalls, the result holds and each stage keeps filling its
// bubbles; in_stall rises only once every stage holds an item.
// Synchronous reset empties the pipeline and sets the offset to zero.
// ----------------------------------------------------------------------------
module unix_time_to_date_and_time_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              tz_offset_we,
  input  logic signed [4:0] tz_offset_hours,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       timestamp,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        second,
  output logic [5:0]        minute,
  output logic [4:0]        hour,
  output logic [4:0]        day,
  output logic [3:0]        month,
  output logic [11:0]       year
);

  localparam int NS = utdt_pkg::STAGES;
  localparam int SS = utdt_pkg::SUB_STAGES;

  logic signed [4:0]  tz_hours;
  logic [NS-1:0]      vld;
  logic [NS-1:0]      vld_next;
  logic [NS:0]        rdy;

  logic signed [16:0] tz_ext;
  logic signed [16:0] shift;
  logic [31:0]        t_sum;

  logic [31:0]        t_a;
  logic [31:0]        t_b;
  logic [15:0]        q0_b;
  logic [15:0]        days_c;
  logic [16:0]        sod_c;

  logic [50:0]        q_prod;
  logic [24:0]        q_back;
  logic [24:0]        r_full;
  logic [10:0]        r;
  logic               r_fix;
  logic [10:0]        r_adj;

  assign tz_ext = 17'(tz_hours);
  assign shift  = tz_ext * 17'sd3600;
  assign t_sum  = timestamp + 32'(shift);

  // Stage B: quotient by 675 of t >> 7, may be one short.
  assign q_prod = 51'(t_a[31:7]) * 51'(utdt_pkg::RECIP_675);

  // Stage C: fix the quotient with one compare and subtract.
  assign q_back = 25'(q0_b) * utdt_pkg::DIV_675;
  assign r_full = t_b[31:7] - q_back;
  assign r      = r_full[10:0];
  assign r_fix  = (r >= 11'd675);
  assign r_adj  = r_fix ? (r - 11'd675) : r;

  // A stage takes new data when it is empty or its content moves on.
  always_comb begin
    rdy[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    vld_next = vld;
    if (rdy[0]) begin
      vld_next[0] = in_valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        vld_next[k] = vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      tz_hours <= '0;
    end else begin
      vld <= vld_next;
      if (tz_offset_we) begin
        tz_hours <= tz_offset_hours;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      t_a <= t_sum;
    end
    if (rdy[1]) begin
      t_b  <= t_a;
      q0_b <= q_prod[50:35];
    end
    if (rdy[2]) begin
      days_c <= q0_b + 16'(r_fix);
      sod_c  <= {r_adj[9:0], t_b[6:0]};
    end
  end

  utdt_tod u_tod (
    .clk    (clk),
    .adv    (rdy[NS-1 -: SS]),
    .sod    (sod_c),
    .second (second),
    .minute (minute),
    .hour   (hour)
  );

  utdt_date u_date (
    .clk   (clk),
    .adv   (rdy[NS-1 -: SS]),
    .days  (days_c),
    .day   (day),
    .month (month),
    .year  (year)
  );

  assign in_stall  = !rdy[0];
  assign out_valid = vld[NS-1];

endmodule

[dv/tb_unix_time_to_date_and_time_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unix_time_to_date_and_time_core
// Drives Unix timestamps into the converter under several time zone offsets
// and checks every result field against a behavioral date decoder, with
// random gaps and stalls on both channels, a long output hold-off and a full
// drain between phases.
// ----------------------------------------------------------------------------
module tb_unix_time_to_date_and_time_core;

  localparam int PIPE_DEPTH     = utdt_pkg::STAGES;
  localparam int SECS_PER_DAY   = 86400;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 200;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } local_time_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              tz_offset_we;
  logic signed [4:0] tz_offset_hours;
  logic              in_valid;
  logic              in_stall;
  logic [31:0]       timestamp;
  logic              out_valid;
  logic              out_stall;
  logic [5:0]        second;
  logic [5:0]        minute;
  logic [4:0]        hour;
  logic [4:0]        day;
  logic [3:0]        month;
  logic [11:0]       year;

  local_time_t       pending_dates[$];
  logic signed [4:0] tz_shadow = 5'sd0;
  bit                tx_gaps_on = 1'b1;
  bit                rx_idle_on = 1'b1;
  int                rx_hold_request = 0;
  int                error_count = 0;
  int                idle_cycles = 0;

  unix_time_to_date_and_time_core dut (
    .clk             (clk),
    .rst             (rst),
    .tz_offset_we    (tz_offset_we),
    .tz_offset_hours (tz_offset_hours),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .timestamp       (timestamp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .second          (second),
    .minute          (minute),
    .hour            (hour),
    .day             (day),
    .month           (month),
    .year            (year)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    case (m)
      2:       return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic int unsigned year_length(input int unsigned y);
    return is_leap_year(y) ? 366 : 365;
  endfunction

  // Seconds from the epoch to January 1 of year y, wrapped to 32 bits.
  function automatic logic [31:0] year_start_secs(input int unsigned y);
    logic [31:0] s;
    s = 32'd0;
    for (int unsigned k = 1970; k < y; k++) s = s + 32'(year_length(k) * SECS_PER_DAY);
    return s;
  endfunction

  function automatic local_time_t predict_local_time(input logic [31:0] ts,
                                                     input logic signed [4:0] tz);
    local_time_t r;
    logic [31:0] t;
    int unsigned days, sod, yr, mo;
    t    = ts + 32'(int'(tz) * 3600);
    days = t / SECS_PER_DAY;
    sod  = t % SECS_PER_DAY;
    yr   = 1970;
    while (days >= year_length(yr)) begin
      days -= year_length(yr);
      yr++;
    end
    mo = 1;
    while (mo < 12 && days >= month_length(mo, yr)) begin
      days -= month_length(mo, yr);
      mo++;
    end
    r.second = 6'(sod % 60);
    r.minute = 6'((sod / 60) % 60);
    r.hour   = 5'(sod / 3600);
    r.day    = 5'(days + 1);
    r.month  = 4'(mo);
    r.year   = 12'(yr);
    return r;
  endfunction

  // Bias toward day, year, leap-day and wrap boundaries; the rest is uniform.
  function automatic logic [31:0] pick_timestamp();
    int unsigned sel, y;
    logic [31:0] base;
    sel = $urandom_range(99);
    y   = $urandom_range(2106, 1970);
    if (sel < 45) return $urandom;
    if (sel < 62) return 32'($urandom_range(49710) * SECS_PER_DAY) + 32'($urandom_range(6)) - 32'd3;
    base = year_start_secs(y);
    if (sel < 77) return base - 32'd50400 + 32'($urandom_range(100800));
    if (sel < 90) return base + 32'(59 * SECS_PER_DAY) - 32'(SECS_PER_DAY)
                        + 32'($urandom_range(3 * SECS_PER_DAY));
    if (sel < 95) return 32'($urandom_range(100000));
    return 32'hFFFF_FFFF - 32'($urandom_range(100000));
  endfunction

  task automatic send_timestamp(input logic [31:0] ts);
    logic stalled;
    while (tx_gaps_on && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    timestamp <= ts;
    // in_stall is settled by the falling edge; it holds through the next rise
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    pending_dates.push_back(predict_local_time(ts, tz_shadow));
  endtask

  // Drop valid, wait out every expected result, then let the pipe run empty.
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (pending_dates.size() > 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_tz_offset(input logic signed [4:0] hours);
    tz_offset_we    <= 1'b1;
    tz_offset_hours <= hours;
    @(posedge clk);
    tz_offset_we    <= 1'b0;
    tz_shadow = hours;
  endtask

  task automatic test_calendar_corners();
    logic [31:0] feb29_2000, mar01_2100, feb29_2104;
    feb29_2000 = year_start_secs(2000) + 32'(59 * SECS_PER_DAY);
    mar01_2100 = year_start_secs(2100) + 32'(59 * SECS_PER_DAY);
    feb29_2104 = year_start_secs(2104) + 32'(59 * SECS_PER_DAY);
    write_tz_offset(5'sd0);
    send_timestamp(32'd0);
    send_timestamp(32'hFFFF_FFFF);
    send_timestamp(32'd86399);
    send_timestamp(32'd86400);
    send_timestamp(32'd68169600);          // leap day, first leap year after the epoch
    send_timestamp(32'd94694399);          // last second of a leap year
    send_timestamp(feb29_2000);            // century leap day (divisible by 400)
    send_timestamp(feb29_2000 + 32'd86399);
    send_timestamp(mar01_2100 - 32'd1);    // 2100 is not a leap year
    send_timestamp(mar01_2100);
    send_timestamp(feb29_2104);
    send_timestamp(32'h7FFF_FFFF);
    send_timestamp(32'h8000_0000);
    send_timestamp(32'hAAAA_AAAA);
    send_timestamp(32'h5555_5555);
    settle_pipeline();
    // negative offset wraps a time near the epoch up to 2106
    write_tz_offset(-5'sd12);
    send_timestamp(32'd0);
    send_timestamp(32'd43199);
    settle_pipeline();
    // positive offset wraps the last second back into 1970
    write_tz_offset(5'sd14);
    send_timestamp(32'hFFFF_FFFF);
    send_timestamp(32'd0);
    settle_pipeline();
    write_tz_offset(-5'sd16);
    send_timestamp(32'd0);
    send_timestamp(32'd57599);
    settle_pipeline();
    write_tz_offset(5'sd15);
    send_timestamp(32'hFFFF_FFFF);
    settle_pipeline();
  endtask

  task automatic test_offset_sweep();
    logic signed [4:0] offsets[6];
    offsets = '{-5'sd12, 5'sd14, -5'sd16, 5'sd15, 5'sd0, 5'sd0};
    offsets[5] = 5'($urandom_range(31));
    foreach (offsets[i]) begin
      write_tz_offset(offsets[i]);
      repeat (PHASE_ITEMS) send_timestamp(pick_timestamp());
      settle_pipeline();
    end
  endtask

  task automatic test_full_rate();
    tx_gaps_on = 1'b0;
    rx_idle_on = 1'b0;
    write_tz_offset(5'($urandom_range(31)));
    repeat (300) send_timestamp(pick_timestamp());
    settle_pipeline();
    tx_gaps_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    write_tz_offset(5'($urandom_range(31)));
    tx_gaps_on = 1'b0;
    rx_hold_request = RX_HOLD_CYCLES;
    repeat (80) send_timestamp(pick_timestamp());
    tx_gaps_on = 1'b1;
    settle_pipeline();
  endtask

  task automatic test_sender_pause();
    write_tz_offset(5'($urandom_range(31)));
    repeat (100) send_timestamp(pick_timestamp());
    settle_pipeline();
    repeat (100) send_timestamp(pick_timestamp());
    settle_pipeline();
  endtask

  task automatic check_field(input string name, input int unsigned expected_val,
                             input int unsigned actual_val);
    if (expected_val != actual_val) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d",
               $time, name, expected_val, actual_val);
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_request > 0) begin
        hold_left = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= rx_idle_on && ($urandom_range(99) < 31);
      end
    end
  end

  // Sample at the falling edge: what is seen here is what the next rise takes.
  always @(negedge clk) begin
    local_time_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_dates.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                   $time, year, month, day, hour, minute, second);
        end else begin
          want = pending_dates.pop_front();
          check_field("second", want.second, second);
          check_field("minute", want.minute, minute);
          check_field("hour", want.hour, hour);
          check_field("day", want.day, day);
          check_field("month", want.month, month);
          check_field("year", want.year, year);
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[unix_time_to_date_and_time_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst             <= 1'b1;
    tz_offset_we    <= 1'b0;
    tz_offset_hours <= 5'sd0;
    in_valid        <= 1'b0;
    timestamp       <= 32'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_calendar_corners();
    test_offset_sweep();
    test_full_rate();
    test_output_backpressure();
    test_sender_pause();

    settle_pipeline();
    if (error_count == 0) begin
      $display("[unix_time_to_date_and_time_core] OK");
    end else begin
      $display("[unix_time_to_date_and_time_core] ERROR");
    end
    $finish;
  end

endmodule

[unix_time_to_date_and_time_core.f]
src/utdt_pkg.sv
src/utdt_tod.sv
src/utdt_date.sv
src/unix_time_to_date_and_time_core.sv
dv/tb_unix_time_to_date_and_time_core.sv
